// File: design/hav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// shared fixed-point types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package hav_pkg;

    typedef logic signed [63:0] q60_t;
    typedef logic [63:0] u64_t;

    localparam u64_t PI_Q60 = 64'h3243F6A8885A308D;
    localparam u64_t ONE_Q60 = 64'd1 << 60;
    localparam u64_t INV_GAIN_Q60 = 64'd700114967507363238;
    localparam u64_t RADIUS_HUNDREDTH_MM = 64'd637279756085;
    // degrees to radians, q66
    localparam u64_t RAD_PER_DEG_Q66 = ((PI_Q60 / 180) << 6) + (((PI_Q60 % 180) << 6) / 180);
    // offset that lifts any angle difference above zero, 360 degrees at 2^24
    localparam int OFFSET_EXP = 24;
    localparam int MUL_LATENCY = 3;
    localparam int SQRT_STEPS = 32;
    // ceil(2^49 / 100): exact floor division by 100 for dividends below 2^42
    localparam int RECIP_SHIFT = 49;
    localparam u64_t RECIP_100 = ((64'd1 << RECIP_SHIFT) + 64'd99) / 100;

    function automatic u64_t pow2_q(input int e);
        u64_t r;
        r = (e < 0) ? 64'd0 : (64'd1 << e);
        return r;
    endfunction

    // atan(2^-i) in q60 by its power series, truncated term by term
    function automatic u64_t atan_q60(input int i);
        u64_t s;
        if (i == 0)
        begin
            s = PI_Q60 >> 2;
        end
        else
        begin
            s = pow2_q(60 - i) - pow2_q(60 - 3 * i) / 3 + pow2_q(60 - 5 * i) / 5
              - pow2_q(60 - 7 * i) / 7 + pow2_q(60 - 9 * i) / 9
              - pow2_q(60 - 11 * i) / 11 + pow2_q(60 - 13 * i) / 13
              - pow2_q(60 - 15 * i) / 15 + pow2_q(60 - 17 * i) / 17
              - pow2_q(60 - 19 * i) / 19 + pow2_q(60 - 21 * i) / 21
              - pow2_q(60 - 23 * i) / 23 + pow2_q(60 - 25 * i) / 25
              - pow2_q(60 - 27 * i) / 27 + pow2_q(60 - 29 * i) / 29
              - pow2_q(60 - 31 * i) / 31 + pow2_q(60 - 33 * i) / 33
              - pow2_q(60 - 35 * i) / 35 + pow2_q(60 - 37 * i) / 37
              - pow2_q(60 - 39 * i) / 39 + pow2_q(60 - 41 * i) / 41
              - pow2_q(60 - 43 * i) / 43 + pow2_q(60 - 45 * i) / 45
              - pow2_q(60 - 47 * i) / 47 + pow2_q(60 - 49 * i) / 49
              - pow2_q(60 - 51 * i) / 51 + pow2_q(60 - 53 * i) / 53
              - pow2_q(60 - 55 * i) / 55 + pow2_q(60 - 57 * i) / 57
              - pow2_q(60 - 59 * i) / 59;
        end
        return s;
    endfunction

endpackage

// File: design/hav_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
module hav_cordic_cell
    import hav_pkg::*;
#(
    parameter int STAGE = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  logic clk,
    input  q60_t x_in,
    input  q60_t y_in,
    input  q60_t z_in,
    output q60_t x_out,
    output q60_t y_out,
    output q60_t z_out
);

    localparam q60_t ATAN = q60_t'(atan_q60(STAGE));

    q60_t x_reg, y_reg, z_reg;
    q60_t x_next, y_next, z_next;
    q60_t dx, dy;
    logic dir;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        dir = VECTOR ? !(y_in > 0) : (z_in >= 0);
        if (dir)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: design/hav_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_sqrt_cell
// one registered digit of a floor square root, two input bits per cell
// ----------------------------------------------------------------------------
module hav_sqrt_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  u64_t v_in,
    input  u64_t res_in,
    output u64_t v_out,
    output u64_t res_out
);

    localparam u64_t BIT = 64'd1 << (62 - 2 * STEP);

    u64_t v_reg, res_reg;
    u64_t v_next, res_next;
    u64_t trial;

    always_comb
    begin
        trial = res_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        res_reg <= res_next;
    end

    assign v_out = v_reg;
    assign res_out = res_reg;

endmodule

// File: design/hav_rdiv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_rdiv_cell
// one registered compare and subtract step of a division by a constant
// ----------------------------------------------------------------------------
module hav_rdiv_cell
    import hav_pkg::*;
#(
    parameter int W = 34,
    parameter int QW = 1,
    parameter u64_t DIV = 64'd1
)
(
    input  logic clk,
    input  logic [W-1:0] r_in,
    input  logic [QW-1:0] q_in,
    output logic [W-1:0] r_out,
    output logic [QW-1:0] q_out
);

    localparam logic [W-1:0] D = DIV[W-1:0];

    logic [W-1:0] r_reg, r_next;
    logic [QW-1:0] q_reg, q_next;
    logic ge;

    always_comb
    begin
        ge = (r_in >= D);
        r_next = ge ? (r_in - D) : r_in;
        q_next = (q_in << 1) | QW'(ge);
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign r_out = r_reg;
    assign q_out = q_reg;

endmodule

// File: design/hav_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_mul
// 62 x 62 unsigned multiply from four 31 x 31 partial products, then shift
// ----------------------------------------------------------------------------
module hav_mul
    import hav_pkg::*;
#(
    parameter int SHIFT = 60
)
(
    input  logic clk,
    input  logic [61:0] a,
    input  logic [61:0] b,
    output u64_t p
);

    logic [61:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [61:0] lo_reg, hi_reg;
    logic [62:0] mid_reg;
    u64_t p_reg;
    logic [123:0] full;

    always_comb
    begin
        full = ({hi_reg, 62'd0}) + (124'(mid_reg) << 31) + 124'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= a[30:0] * b[30:0];
        p01_reg <= a[30:0] * b[61:31];
        p10_reg <= a[61:31] * b[30:0];
        p11_reg <= a[61:31] * b[61:31];
        lo_reg <= p00_reg;
        hi_reg <= p11_reg;
        mid_reg <= 63'(p01_reg) + 63'(p10_reg);
        p_reg <= full[SHIFT +: 64];
    end

    assign p = p_reg;

endmodule

// File: design/haversine_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_top
// great-circle distance in millimetres between two positions, fully pipelined
// ----------------------------------------------------------------------------
// A position pair is transferred at a rising edge with start high and busy
// low. busy stays low: a new pair is taken in every cycle, pairs are
// independent and travel down one fixed pipeline.
// The distance leaves on distance_mm with done high for one cycle.
// Throughput is one pair per cycle.
// The latency is set by the chain: angle reduction cells, degree-to-radian
// multiply, rotation cordic, two q60 multiplies, a 32-cell square root,
// vectoring cordic, radius multiply and a reciprocal multiply for the
// division by 100.
// The receiver cannot stall: done is a strobe and results do not wait.
// Reset clears only the valid line; no results come out until pairs are
// transferred after reset.
// ----------------------------------------------------------------------------
module haversine_distance_top
    import hav_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 23,
    parameter int CORDIC_STAGES = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic done,
    output logic [34:0] distance_mm
);

    localparam int F = ANGLE_FRAC_BITS;
    localparam int CS = CORDIC_STAGES;
    localparam int NR = OFFSET_EXP + 1 - F;
    localparam int L = 53 + NR + 2 * CS;
    localparam int NEG_DLY = MUL_LATENCY + CS;
    localparam int SX_DLY = 2 * MUL_LATENCY;
    localparam logic [33:0] FULL_TURN = 34'(360) << F;
    localparam logic [33:0] HALF_TURN = 34'(180) << F;
    localparam logic [33:0] QUARTER_TURN = 34'(90) << F;
    localparam logic signed [34:0] OFFSET = 35'(360) << OFFSET_EXP;
    localparam q60_t Z_MAX = q60_t'(PI_Q60 >> 1);

    function automatic logic [61:0] mag62(input q60_t v);
        q60_t m;
        m = (v < 0) ? -v : v;
        return m[61:0];
    endfunction

    logic accept;
    logic [L-1:0] valid_reg;

    assign busy = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[L-2:0], accept};
        end
    end

    assign done = valid_reg[L-1];

    // input and offset stages
    logic signed [30:0] lat_a_reg, lat_b_reg;
    logic signed [31:0] lon_a_reg, lon_b_reg;
    logic [33:0] r1_reg [4];
    logic signed [34:0] d0, d1, d2, d3;

    always_comb
    begin
        d0 = 35'(lat_a_reg) - 35'(lat_b_reg) + OFFSET;
        d1 = 35'(lon_a_reg) - 35'(lon_b_reg) + OFFSET;
        d2 = 35'(lat_a_reg) + OFFSET;
        d3 = 35'(lat_b_reg) + OFFSET;
    end

    always_ff @(posedge clk)
    begin
        lat_a_reg <= lat_a;
        lon_a_reg <= lon_a;
        lat_b_reg <= lat_b;
        lon_b_reg <= lon_b;
        r1_reg[0] <= d0[33:0];
        r1_reg[1] <= d1[33:0];
        r1_reg[2] <= d2[33:0];
        r1_reg[3] <= d3[33:0];
    end

    // lanes: dlat sine, dlon sine, cosine of lat_a, cosine of lat_b
    logic [33:0] fr [4][NR+1];
    logic fq [4][NR+1];

    genvar l, j;
    generate
        for (l = 0; l < 4; l++)
        begin : g_fold
            assign fr[l][0] = r1_reg[l];
            assign fq[l][0] = 1'b0;
            for (j = 0; j < NR; j++)
            begin : g_cell
                hav_rdiv_cell #(
                    .W(34),
                    .QW(1),
                    .DIV(64'd360 << (OFFSET_EXP - j))
                ) u_cell (
                    .clk(clk),
                    .r_in(fr[l][j]),
                    .q_in(fq[l][j]),
                    .r_out(fr[l][j+1]),
                    .q_out(fq[l][j+1])
                );
            end
        end
    endgenerate

    // fold to [0, 180] degrees, and for cosines to [0, 90] with a sign
    logic [30:0] m_reg [4];
    logic [1:0] neg_reg;
    logic [33:0] fm [4];
    logic [33:0] fc [4];
    logic [1:0] neg_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            fm[i] = (fr[i][NR] > HALF_TURN) ? (FULL_TURN - fr[i][NR]) : fr[i][NR];
            fc[i] = fm[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            neg_next[i] = (fm[i+2] > QUARTER_TURN);
            fc[i+2] = neg_next[i] ? (HALF_TURN - fm[i+2]) : fm[i+2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            m_reg[i] <= fc[i][30:0];
        end
        neg_reg <= neg_next;
    end

    // degrees to radians
    u64_t rad [4];
    q60_t rx [4][CS+1];
    q60_t ry [4][CS+1];
    q60_t rz [4][CS+1];

    generate
        for (l = 0; l < 4; l++)
        begin : g_rot
            hav_mul #(.SHIFT(6 + F)) u_rad (
                .clk(clk),
                .a(62'(m_reg[l])),
                .b(RAD_PER_DEG_Q66[61:0]),
                .p(rad[l])
            );
            assign rx[l][0] = q60_t'(INV_GAIN_Q60);
            assign ry[l][0] = '0;
            // sine lanes work on the half angle
            assign rz[l][0] = (l < 2) ? q60_t'(rad[l] >> 1) : q60_t'(rad[l]);
            for (j = 0; j < CS; j++)
            begin : g_cell
                hav_cordic_cell #(.STAGE(j), .VECTOR(1'b0)) u_cell (
                    .clk(clk),
                    .x_in(rx[l][j]),
                    .y_in(ry[l][j]),
                    .z_in(rz[l][j]),
                    .x_out(rx[l][j+1]),
                    .y_out(ry[l][j+1]),
                    .z_out(rz[l][j+1])
                );
            end
        end
    endgenerate

    logic [1:0] neg_line [NEG_DLY];

    always_ff @(posedge clk)
    begin
        neg_line[0] <= neg_reg;
        for (int i = 1; i < NEG_DLY; i++)
        begin
            neg_line[i] <= neg_line[i-1];
        end
    end

    // magnitudes and cosine product sign
    logic [61:0] u_reg [4];
    logic sx_reg;
    logic sa, sb;
    q60_t ca, cb;

    always_comb
    begin
        ca = rx[2][CS];
        cb = rx[3][CS];
        sa = neg_line[NEG_DLY-1][0] ? (ca > 0) : (ca < 0);
        sb = neg_line[NEG_DLY-1][1] ? (cb > 0) : (cb < 0);
    end

    always_ff @(posedge clk)
    begin
        u_reg[0] <= mag62(ry[0][CS]);
        u_reg[1] <= mag62(ry[1][CS]);
        u_reg[2] <= mag62(ca);
        u_reg[3] <= mag62(cb);
        sx_reg <= sa ^ sb;
    end

    u64_t s1, s2, cc, t;

    hav_mul #(.SHIFT(60)) u_s1 (.clk(clk), .a(u_reg[0]), .b(u_reg[0]), .p(s1));
    hav_mul #(.SHIFT(60)) u_s2 (.clk(clk), .a(u_reg[1]), .b(u_reg[1]), .p(s2));
    hav_mul #(.SHIFT(60)) u_cc (.clk(clk), .a(u_reg[2]), .b(u_reg[3]), .p(cc));
    hav_mul #(.SHIFT(60)) u_t (.clk(clk), .a(cc[61:0]), .b(s2[61:0]), .p(t));

    u64_t s1_line [MUL_LATENCY];
    logic sx_line [SX_DLY];

    always_ff @(posedge clk)
    begin
        s1_line[0] <= s1;
        for (int i = 1; i < MUL_LATENCY; i++)
        begin
            s1_line[i] <= s1_line[i-1];
        end
        sx_line[0] <= sx_reg;
        for (int i = 1; i < SX_DLY; i++)
        begin
            sx_line[i] <= sx_line[i-1];
        end
    end

    // term a, clamped to [0, 1]
    logic [60:0] ua_reg;
    logic signed [64:0] a_sum;
    logic [60:0] ua_next;

    always_comb
    begin
        if (sx_line[SX_DLY-1])
        begin
            a_sum = 65'(s1_line[MUL_LATENCY-1]) - 65'(t);
        end
        else
        begin
            a_sum = 65'(s1_line[MUL_LATENCY-1]) + 65'(t);
        end
        if (a_sum < 0)
        begin
            ua_next = '0;
        end
        else if (a_sum > 65'(ONE_Q60))
        begin
            ua_next = ONE_Q60[60:0];
        end
        else
        begin
            ua_next = a_sum[60:0];
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg <= ua_next;
    end

    // square roots of 4a and 4(1 - a)
    u64_t sv [2][SQRT_STEPS+1];
    u64_t sr [2][SQRT_STEPS+1];

    assign sv[0][0] = 64'(ua_reg) << 2;
    assign sv[1][0] = (ONE_Q60 - 64'(ua_reg)) << 2;

    generate
        for (l = 0; l < 2; l++)
        begin : g_sqrt
            assign sr[l][0] = '0;
            for (j = 0; j < SQRT_STEPS; j++)
            begin : g_cell
                hav_sqrt_cell #(.STEP(j)) u_cell (
                    .clk(clk),
                    .v_in(sv[l][j]),
                    .res_in(sr[l][j]),
                    .v_out(sv[l][j+1]),
                    .res_out(sr[l][j+1])
                );
            end
        end
    endgenerate

    // atan2 by vectoring
    q60_t vx [CS+1];
    q60_t vy [CS+1];
    q60_t vz [CS+1];

    assign vx[0] = q60_t'(sr[1][SQRT_STEPS] << 28);
    assign vy[0] = q60_t'(sr[0][SQRT_STEPS] << 28);
    assign vz[0] = '0;

    generate
        for (j = 0; j < CS; j++)
        begin : g_vec
            hav_cordic_cell #(.STAGE(j), .VECTOR(1'b1)) u_cell (
                .clk(clk),
                .x_in(vx[j]),
                .y_in(vy[j]),
                .z_in(vz[j]),
                .x_out(vx[j+1]),
                .y_out(vy[j+1]),
                .z_out(vz[j+1])
            );
        end
    endgenerate

    // clamp caps the distance at half the circumference
    logic [60:0] zc_reg;
    logic [60:0] zc_next;

    always_comb
    begin
        if (vz[CS] < 0)
        begin
            zc_next = '0;
        end
        else if (vz[CS] > Z_MAX)
        begin
            zc_next = Z_MAX[60:0];
        end
        else
        begin
            zc_next = vz[CS][60:0];
        end
    end

    always_ff @(posedge clk)
    begin
        zc_reg <= zc_next;
    end

    u64_t dist_hmm;

    hav_mul #(.SHIFT(59)) u_dist (
        .clk(clk),
        .a(RADIUS_HUNDREDTH_MM[61:0]),
        .b(62'(zc_reg)),
        .p(dist_hmm)
    );

    // hundredths of a millimetre to millimetres
    u64_t quot;

    hav_mul #(.SHIFT(RECIP_SHIFT)) u_div (
        .clk(clk),
        .a(62'(dist_hmm[41:0])),
        .b(RECIP_100[61:0]),
        .p(quot)
    );

    assign distance_mm = quot[34:0];

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// haversine distance pipeline: directed and random position pairs, each
// distance predicted in fixed point and compared in order of arrival
// ----------------------------------------------------------------------------
module testbench
    import hav_pkg::*;
();

    localparam int FRAC = 23;
    localparam int STAGES = 32;
    localparam int LATENCY = 53 + (25 - FRAC) + 2 * STAGES;
    localparam longint TURN = longint'(360) << FRAC;
    localparam longint LAT_MAX = 754974720;
    localparam longint LON_MAX = 1509949440;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic done;
    logic [34:0] distance_mm;

    logic [34:0] pending_mm[$];
    u64_t atan_tab[STAGES];
    int errors = 0;
    int pairs_sent = 0;
    int distances_seen = 0;
    int cycles = 0;
    bit calm = 0;

    haversine_distance_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
        .done(done), .distance_mm(distance_mm)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---- fixed-point predictor ----
    function automatic u64_t prod_shr(input u64_t a, input u64_t b, input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic u64_t arctan_step(input int i);
        u64_t sum;
        int e;
        if (i == 0)
            return PI_Q60 >> 2;
        sum = 0;
        for (int k = 0; k < 64; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e < 0)
                break;
            if (k % 2 == 1)
                sum = sum - (u64_t'(1) << e) / (2 * k + 1);
            else
                sum = sum + (u64_t'(1) << e) / (2 * k + 1);
        end
        return sum;
    endfunction

    function automatic u64_t abs64(input q60_t v);
        return (v < 0) ? u64_t'(-v) : u64_t'(v);
    endfunction

    // magnitude of the angle wrapped into [-180, 180] degrees
    function automatic u64_t wrap_mag(input longint x);
        longint r;
        r = x % TURN;
        if (r < 0)
            r = r + TURN;
        if (r > TURN / 2)
            r = TURN - r;
        return u64_t'(r);
    endfunction

    function automatic q60_t deg_to_rad(input u64_t m);
        return q60_t'(prod_shr(m, RAD_PER_DEG_Q66, 6 + FRAC));
    endfunction

    function automatic void cordic_rotate(input q60_t ang, output q60_t c, output q60_t s);
        q60_t x, y, dx, dy;
        x = q60_t'(INV_GAIN_Q60);
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0)
            begin
                x = x - dx; y = y + dy; ang = ang - q60_t'(atan_tab[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; ang = ang + q60_t'(atan_tab[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic q60_t cordic_angle(input q60_t x, input q60_t y);
        q60_t z, dx, dy;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + q60_t'(atan_tab[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - q60_t'(atan_tab[i]);
            end
        end
        return z;
    endfunction

    function automatic q60_t signed_cos(input longint x);
        u64_t m;
        bit neg;
        q60_t c, s;
        m = wrap_mag(x);
        neg = m > u64_t'(TURN / 4);
        if (neg)
            m = u64_t'(TURN / 2) - m;
        cordic_rotate(deg_to_rad(m), c, s);
        return neg ? -c : c;
    endfunction

    function automatic u64_t sin_half_sq(input longint x);
        q60_t c, s;
        u64_t u;
        cordic_rotate(deg_to_rad(wrap_mag(x)) >>> 1, c, s);
        u = abs64(s);
        return prod_shr(u, u, 60);
    endfunction

    function automatic u64_t floor_sqrt(input u64_t v);
        u64_t res, bitv;
        res = 0;
        bitv = u64_t'(1) << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [34:0] great_circle_mm(input logic signed [30:0] la,
        input logic signed [31:0] oa, input logic signed [30:0] lb,
        input logic signed [31:0] ob);
        longint pa, pb, qa, qb;
        u64_t s1, s2, cc, ua, ys, xs;
        q60_t ca, cb, t, a, z;
        pa = la; pb = lb; qa = oa; qb = ob;
        s1 = sin_half_sq(pa - pb);
        s2 = sin_half_sq(qa - qb);
        ca = signed_cos(pa);
        cb = signed_cos(pb);
        cc = prod_shr(abs64(ca), abs64(cb), 60);
        t = q60_t'(prod_shr(cc, s2, 60));
        a = q60_t'(s1) + (((ca < 0) != (cb < 0)) ? -t : t);
        if (a < 0)
            a = 0;
        if (a > q60_t'(ONE_Q60))
            a = q60_t'(ONE_Q60);
        ua = u64_t'(a);
        ys = floor_sqrt(ua << 2);
        xs = floor_sqrt((ONE_Q60 - ua) << 2);
        z = cordic_angle(q60_t'(xs << 28), q60_t'(ys << 28));
        if (z < 0)
            z = 0;
        if (z > q60_t'(PI_Q60 >> 1))
            z = q60_t'(PI_Q60 >> 1);
        return 35'(prod_shr(RADIUS_HUNDREDTH_MM, u64_t'(z), 59) / 100);
    endfunction

    // ---- stimulus ----
    task automatic send_pair(input longint la, input longint oa,
        input longint lb, input longint ob, input bit idle_ok);
        while (idle_ok && !calm && $urandom_range(99) < 36)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        lat_a = la[30:0];
        lon_a = oa[31:0];
        lat_b = lb[30:0];
        lon_b = ob[31:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_mm.push_back(great_circle_mm(lat_a, lon_a, lat_b, lon_b));
        pairs_sent++;
        @(negedge clk);
    endtask

    function automatic longint rand_in(input longint lim);
        return longint'($urandom_range(32'(2 * lim))) - lim;
    endfunction

    task automatic test_directed;
        send_pair(0, 0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);                 // pole to pole
        send_pair(0, 0, 0, LON_MAX, 0);                        // antipodes on equator
        send_pair(0, -LON_MAX, 0, LON_MAX, 0);                 // same point across wrap
        send_pair(LAT_MAX, 123456, LAT_MAX, -987654, 0);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 0);
        send_pair(100, 0, 0, 0, 0);
        send_pair(0, 1, 0, 0, 0);
        send_pair(-(longint'(1) << 30), 0, (longint'(1) << 30) - 1, 0, 0);  // past the poles
        send_pair((longint'(1) << 30) - 1, -(longint'(1) << 31),
                  -(longint'(1) << 30), (longint'(1) << 31) - 1, 0);
        send_pair(-1, -1, -1, -1, 0);
        send_pair(LAT_MAX - 1, LON_MAX - 1, -LAT_MAX + 1, -LON_MAX + 1, 0);
        send_pair(900000000, 0, 0, LON_MAX, 0);                // cosine turns negative
        send_pair(-900000000, 40000000, 900000000, -40000000, 0);
        send_pair(377487360, 0, -377487360, LON_MAX, 0);       // antipodal
        send_pair(377487360, 5, -377487360, LON_MAX, 0);
    endtask

    task automatic test_random_positions(input int n);
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3) && (i < n / 3 + 150);
            send_pair(rand_in(LAT_MAX), rand_in(LON_MAX), rand_in(LAT_MAX),
                      rand_in(LON_MAX), 1);
        end
        calm = 0;
    endtask

    // short hops and near-antipodal pairs stress the ends of the range
    task automatic test_near_pairs(input int n);
        longint la, oa, d;
        for (int i = 0; i < n; i++)
        begin
            la = rand_in(LAT_MAX);
            oa = rand_in(LON_MAX);
            d = longint'(1) << $urandom_range(20);
            if ($urandom_range(1))
                send_pair(la, oa, la + rand_in(d), oa + rand_in(d), 1);
            else
                send_pair(la, oa, -la + rand_in(d), oa + LON_MAX + rand_in(d), 1);
        end
    endtask

    task automatic test_raw_bits(input int n);
        for (int i = 0; i < n; i++)
            send_pair(longint'($urandom), longint'($urandom), longint'($urandom),
                      longint'($urandom), 1);
    endtask

    // ---- result check ----
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            distances_seen++;
            if (pending_mm.size() == 0)
            begin
                $error("distance_mm transfer with none expected: actual %0d", distance_mm);
                errors++;
            end
            else
            begin
                logic [34:0] want;
                want = pending_mm.pop_front();
                if (distance_mm !== want)
                begin
                    $error("distance_mm: expected %0d, actual %0d", want, distance_mm);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < STAGES; i++)
            atan_tab[i] = arctan_step(i);
        rst_n = 1'b0;
        start = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_positions(900);
        test_near_pairs(650);
        test_raw_bits(300);
        start = 1'b0;
        while (pending_mm.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("%0d position pairs sent, %0d distances checked", pairs_sent, distances_seen);
        $display("covered poles, antipodes, longitude wrap, past-pole latitudes, raw bits");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
